/* hdl/qte_pkg.sv */
// Shared types, constants and helper function of the quaternion to Euler angle converter.
package qte_pkg;

    // Width of the signed operands that enter an arctangent unit.
    localparam int CIN_W = 35;
    // Width of the rotation datapath inside an arctangent unit.
    localparam int CW = 38;
    // Width of the magnitude word used by the normalizing shifter.
    localparam int MAG_W = 34;
    // Width of the radicand of the pitch square root.
    localparam int SQ_W = 61;
    // One pipeline stage per result bit of the square root.
    localparam int SQ_STAGES = 31;
    // Stages of an arctangent unit ahead of its rotation steps.
    localparam int CORDIC_PRE = 8;
    // Largest number of rotation steps that the arctangent table covers.
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_HALF = 32'h8000_0000;

    localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } t_qte_pole;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_qte_quat;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic [1:0]         pole_status;
    } t_qte_euler;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        t_qte_pole                pole;
        logic                     neg;
        logic signed [CIN_W-1:0]  yaw_y;
        logic signed [CIN_W-1:0]  yaw_x;
        logic signed [CIN_W-1:0]  roll_y;
        logic signed [CIN_W-1:0]  roll_x;
        logic [30:0]              pit_s;
        logic [30:0]              pit_d;
        logic [31:0]              pit_a;
    } t_qte_item;

    typedef struct packed {
        logic [1:0] inflight;
    } t_qte_front_stat;

    // Rounds a 32-bit turn fraction to aw bits and sign-extends it into a 16-bit field.
    function automatic logic [15:0] to_field(input logic [31:0] z, input int unsigned aw);
        logic [31:0] zr;
        logic [31:0] v;
        logic [15:0] f;
        zr = z;
        if (aw < 32) begin
            zr = z + (32'd1 << (31 - aw));
        end
        v = zr >> (32 - aw);
        for (int b = 0; b < 16; b++) begin
            f[b] = (b < aw) ? v[b] : v[aw-1];
        end
        return f;
    endfunction

endpackage

/* hdl/qte_front.sv */
// Front end: products, sums, pole classification and operand selection.
module qte_front import qte_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  t_qte_quat       i_quat,
    input  logic [15:0]     i_margin,
    output logic            o_push,
    output t_qte_item       o_item,
    output t_qte_front_stat o_stat
);

    localparam int FW = 37;
    localparam logic signed [FW-1:0] ONE_Q28 = FW'(1) <<< 28;

    logic r_v1, r_v2, r_v3;
    logic signed [31:0] r_w2, r_x2, r_y2, r_z2;
    logic signed [31:0] r_p01, r_p23, r_p03, r_p12, r_p02, r_p13;
    logic signed [15:0] r_q0, r_q2, r_q0b, r_q2b;
    logic signed [FW-1:0] r_norm, r_cross2, r_adbc2, r_acbd2, r_yawx, r_rollx;
    t_qte_item r_item;

    logic signed [15:0] q0, q1, q2, q3;
    logic signed [FW-1:0] marg2, lim, across;
    logic [30:0] s0, mm, ss;
    logic north, south;

    assign q0 = i_quat.quat_w;
    assign q1 = i_quat.quat_x;
    assign q2 = i_quat.quat_y;
    assign q3 = i_quat.quat_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w2  <= q0 * q0;
        r_x2  <= q1 * q1;
        r_y2  <= q2 * q2;
        r_z2  <= q3 * q3;
        r_p01 <= q0 * q1;
        r_p23 <= q2 * q3;
        r_p03 <= q0 * q3;
        r_p12 <= q1 * q2;
        r_p02 <= q0 * q2;
        r_p13 <= q1 * q3;
        r_q0  <= q0;
        r_q2  <= q2;
    end

    always_ff @(posedge i_clk) begin
        r_norm   <= FW'(r_w2) + FW'(r_x2) + FW'(r_y2) + FW'(r_z2);
        r_cross2 <= (FW'(r_p01) + FW'(r_p23)) <<< 1;
        r_adbc2  <= (FW'(r_p03) - FW'(r_p12)) <<< 1;
        r_acbd2  <= (FW'(r_p02) - FW'(r_p13)) <<< 1;
        r_yawx   <= ONE_Q28 - ((FW'(r_z2) + FW'(r_x2)) <<< 1);
        r_rollx  <= ONE_Q28 - ((FW'(r_y2) + FW'(r_x2)) <<< 1);
        r_q0b    <= r_q0;
        r_q2b    <= r_q2;
    end

    always_comb begin
        marg2  = $signed(FW'({i_margin, 1'b0}));
        lim    = r_norm - marg2;
        north  = r_cross2 > lim;
        south  = !north && (r_cross2 < -lim);
        across = (r_cross2 < 0) ? -r_cross2 : r_cross2;
        s0     = across[32:2];
        mm     = r_norm[32:2];
        ss     = (s0 > mm) ? mm : s0;
    end

    always_ff @(posedge i_clk) begin
        r_item.pole   <= north ? POLE_NORTH : (south ? POLE_SOUTH : POLE_NONE);
        r_item.neg    <= r_cross2 < 0;
        r_item.yaw_y  <= (north || south) ? CIN_W'(r_q2b) : CIN_W'(r_adbc2);
        r_item.yaw_x  <= (north || south) ? CIN_W'(r_q0b) : CIN_W'(r_yawx);
        r_item.roll_y <= CIN_W'(r_acbd2);
        r_item.roll_x <= CIN_W'(r_rollx);
        r_item.pit_s  <= ss;
        r_item.pit_d  <= mm - ss;
        r_item.pit_a  <= {1'b0, mm} + {1'b0, ss};
    end

    assign o_push = r_v3;
    assign o_item = r_item;
    assign o_stat.inflight = 2'(r_v1) + 2'(r_v2) + 2'(r_v3);

endmodule

/* hdl/qte_fifo.sv */
// Short queue of classified items between the front end and the back end.
module qte_fifo import qte_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_qte_item                  i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output t_qte_item                  o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    t_qte_item r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr, r_rd;
    logic [CNW-1:0] r_count;
    logic do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNW'(i_push) - CNW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

/* hdl/qte_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
module qte_isqrt import qte_pkg::*; (
    input  logic            i_clk,
    input  logic [SQ_W-1:0] i_v,
    output logic [30:0]     o_r
);

    localparam int RW = SQ_W + 1;

    logic [RW-1:0] r_rem [0:SQ_STAGES-1];
    logic [RW-1:0] r_root [0:SQ_STAGES-1];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STAGES - 1 - k));
        logic [RW-1:0] rem_in, root_in, trial;
        if (k == 0) begin : g_first
            assign rem_in  = RW'(i_v);
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        assign trial = root_in + BIT;
        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[k]  <= rem_in - trial;
                r_root[k] <= (root_in >> 1) + BIT;
            end else begin
                r_rem[k]  <= rem_in;
                r_root[k] <= root_in >> 1;
            end
        end
    end

    assign o_r = r_root[SQ_STAGES-1][30:0];

endmodule

/* hdl/qte_cordic.sv */
// Pipelined vectoring arctangent: normalizing shifter, half-turn fold, rotation steps.
module qte_cordic import qte_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                    i_clk,
    input  logic signed [CIN_W-1:0] i_y,
    input  logic signed [CIN_W-1:0] i_x,
    output logic [31:0]             o_z
);

    localparam int NS = 6;

    logic signed [CW-1:0] r_nx [0:NS];
    logic signed [CW-1:0] r_ny [0:NS];
    logic [MAG_W-1:0]     r_mg [0:NS];
    logic signed [CW-1:0] r_ix [0:STEPS];
    logic signed [CW-1:0] r_iy [0:STEPS];
    logic [31:0]          r_iz [0:STEPS];
    logic                 r_zero [0:STEPS];

    logic signed [CIN_W-1:0] ax, ay;

    assign ax = (i_x < 0) ? -i_x : i_x;
    assign ay = (i_y < 0) ? -i_y : i_y;

    always_ff @(posedge i_clk) begin
        r_nx[0] <= CW'(i_x);
        r_ny[0] <= CW'(i_y);
        r_mg[0] <= ax[MAG_W-1:0] | ay[MAG_W-1:0];
    end

    // Binary search for the left shift that brings the larger magnitude to 2^32.
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int SH = (j < NS - 1) ? (16 >> j) : 1;
        localparam int TH = (j < NS - 1) ? (32 - SH) : 32;
        always_ff @(posedge i_clk) begin
            if (r_mg[j] < (MAG_W'(1) << TH)) begin
                r_nx[j+1] <= r_nx[j] <<< SH;
                r_ny[j+1] <= r_ny[j] <<< SH;
                r_mg[j+1] <= r_mg[j] << SH;
            end else begin
                r_nx[j+1] <= r_nx[j];
                r_ny[j+1] <= r_ny[j];
                r_mg[j+1] <= r_mg[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= r_mg[NS] == '0;
        if (r_nx[NS] < 0) begin
            r_ix[0] <= -r_nx[NS];
            r_iy[0] <= -r_ny[NS];
            r_iz[0] <= TURN_HALF;
        end else begin
            r_ix[0] <= r_nx[NS];
            r_iy[0] <= r_ny[NS];
            r_iz[0] <= '0;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
        logic signed [CW-1:0] xs, ys;
        assign xs = r_ix[i] >>> i;
        assign ys = r_iy[i] >>> i;
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_iy[i] > 0) begin
                r_ix[i+1] <= r_ix[i] + ys;
                r_iy[i+1] <= r_iy[i] - xs;
                r_iz[i+1] <= r_iz[i] + ATAN_TAB[i];
            end else begin
                r_ix[i+1] <= r_ix[i] - ys;
                r_iy[i+1] <= r_iy[i] + xs;
                r_iz[i+1] <= r_iz[i] - ATAN_TAB[i];
            end
        end
    end

    assign o_z = r_zero[STEPS] ? 32'd0 : r_iz[STEPS];

endmodule

/* hdl/qte_back.sv */
// Back end: pitch radicand and square root, three arctangent units, pole fix-up and rounding.
module qte_back import qte_pkg::*; #(
    parameter int STEPS = 16,
    parameter int AW = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_qte_item  i_item,
    output logic       o_strobe,
    output t_qte_euler o_result
);

    localparam int LC = CORDIC_PRE + STEPS;
    localparam int DSQ = SQ_STAGES + 1;
    localparam int DT = DSQ + LC;

    logic            r_b0v;
    t_qte_item       r_b0;
    logic [SQ_W-1:0] r_prod;
    logic [30:0]     r_sdl [0:DSQ-1];
    logic [31:0]     r_ydl [0:DSQ-1];
    logic [31:0]     r_rdl [0:DSQ-1];
    t_qte_pole       r_pdl [0:DT-1];
    logic            r_ndl [0:DT-1];
    logic            r_vdl [0:DT-1];
    logic            r_strobe;
    t_qte_euler      r_out;

    logic [63:0] prod;
    logic [30:0] hroot;
    logic [31:0] yaw_z, roll_z, pit_z;
    logic [31:0] yaw_f, pit_f, roll_f;
    t_qte_pole   pole;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0v <= 1'b0;
        end else begin
            r_b0v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= i_item;
    end

    assign prod = 64'(r_b0.pit_d) * 64'(r_b0.pit_a);

    always_ff @(posedge i_clk) begin
        r_prod <= prod[SQ_W-1:0];
    end

    qte_isqrt u_isqrt (
        .i_clk (i_clk),
        .i_v   (r_prod),
        .o_r   (hroot)
    );

    qte_cordic #(.STEPS(STEPS)) u_yaw (
        .i_clk (i_clk),
        .i_y   (r_b0.yaw_y),
        .i_x   (r_b0.yaw_x),
        .o_z   (yaw_z)
    );

    qte_cordic #(.STEPS(STEPS)) u_roll (
        .i_clk (i_clk),
        .i_y   (r_b0.roll_y),
        .i_x   (r_b0.roll_x),
        .o_z   (roll_z)
    );

    qte_cordic #(.STEPS(STEPS)) u_pitch (
        .i_clk (i_clk),
        .i_y   ($signed(CIN_W'(r_sdl[DSQ-1]))),
        .i_x   ($signed(CIN_W'(hroot))),
        .o_z   (pit_z)
    );

    always_ff @(posedge i_clk) begin
        r_sdl[0] <= r_b0.pit_s;
        r_ydl[0] <= yaw_z;
        r_rdl[0] <= roll_z;
        for (int k = 1; k < DSQ; k++) begin
            r_sdl[k] <= r_sdl[k-1];
            r_ydl[k] <= r_ydl[k-1];
            r_rdl[k] <= r_rdl[k-1];
        end
        r_pdl[0] <= r_b0.pole;
        r_ndl[0] <= r_b0.neg;
        for (int k = 1; k < DT; k++) begin
            r_pdl[k] <= r_pdl[k-1];
            r_ndl[k] <= r_ndl[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DT; k++) begin
                r_vdl[k] <= 1'b0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_vdl[0] <= r_b0v;
            for (int k = 1; k < DT; k++) begin
                r_vdl[k] <= r_vdl[k-1];
            end
            r_strobe <= r_vdl[DT-1];
        end
    end

    assign pole = r_pdl[DT-1];

    always_comb begin
        case (pole)
            POLE_NORTH: begin
                yaw_f  = {r_ydl[DSQ-1][30:0], 1'b0};
                pit_f  = TURN_QUARTER;
                roll_f = '0;
            end
            POLE_SOUTH: begin
                yaw_f  = 32'd0 - {r_ydl[DSQ-1][30:0], 1'b0};
                pit_f  = 32'd0 - TURN_QUARTER;
                roll_f = '0;
            end
            default: begin
                yaw_f  = r_ydl[DSQ-1];
                pit_f  = r_ndl[DT-1] ? 32'd0 - pit_z : pit_z;
                roll_f = r_rdl[DSQ-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out.yaw_angle   <= $signed(to_field(yaw_f, AW));
        r_out.pitch_angle <= $signed(to_field(pit_f, AW));
        r_out.roll_angle  <= $signed(to_field(roll_f, AW));
        r_out.pole_status <= pole;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

/* hdl/quaternion_to_euler_angles.sv */
// Top level of the quaternion to Euler angle converter.
//
// One quaternion beat (signed Q1.14 components w, x, y, z) enters on i_quat and is
// taken at a rising edge where start is high and busy is low. Each beat yields
// exactly one result beat on o_result: yaw, pitch and roll as binary angles
// (half scale is pi) and a pole status that flags the two gimbal-lock poles.
// The result stands on o_result for one cycle with o_strobe high; the receiver
// cannot hold it off, so the back end never stalls.
// Throughput is one beat per cycle while busy is low. The front end registers the
// products, then the sums, then the pole test and operands, and feeds a short queue;
// the back end runs a pitch square root of 31 pipelined bit stages followed by a
// CORDIC unit of CORDIC_STEPS + 8 stages, and its yaw and roll results are delayed
// to match. Results appear in input order.
// busy rises only if the queue could not absorb the beats already in the front
// end; with the back end draining every cycle it stays low.
// The user must write the pole margin register through i_cfg_we / i_cfg_data only while
// the block is idle; the block itself does not enforce this. Synchronous reset empties
// the pipeline and queue, drops any pending results and sets the pole margin to 27.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_qte_quat   i_quat,
    output logic        o_strobe,
    output t_qte_euler  o_result,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);

    localparam int QDEPTH = 8;
    localparam int CNW = $clog2(QDEPTH + 1);

    logic [15:0] r_pole_margin;

    logic            accept;
    logic            push;
    t_qte_item       push_item;
    t_qte_front_stat fstat;
    logic            q_valid;
    t_qte_item       q_item;
    logic [CNW-1:0]  q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_margin <= 16'd27;
        end else if (i_cfg_we) begin
            r_pole_margin <= i_cfg_data;
        end
    end

    // Hold off new beats when the queue plus the beats still in the front end could overflow.
    assign busy   = (32'(q_count) + 32'(fstat.inflight)) >= 32'(QDEPTH);
    assign accept = start && !busy;

    qte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_quat   (i_quat),
        .i_margin (r_pole_margin),
        .o_push   (push),
        .o_item   (push_item),
        .o_stat   (fstat)
    );

    qte_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (1'b1),
        .o_valid (q_valid),
        .o_data  (q_item),
        .o_count (q_count)
    );

    qte_back #(.STEPS(CORDIC_STEPS), .AW(ANGLE_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

/* test/tb_quaternion_to_euler_angles.sv */
// Self-checking testbench for the quaternion to Euler angle converter.
module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    localparam int STEPS = 16;
    // Quiet time before a margin write, with a little slack added.
    localparam int QUIET_CYCLES = 45 + STEPS + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        JOB_QUAT   = 2'd0,
        JOB_MARGIN = 2'd1,
        JOB_DRAIN  = 2'd2
    } t_job_kind;

    typedef struct {
        t_job_kind   kind;
        t_qte_quat   quat;
        logic [15:0] margin;
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_qte_quat   i_quat = '0;
    logic        o_strobe;
    t_qte_euler  o_result;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS), .ANGLE_WIDTH(16)) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_quat    (i_quat),
        .o_strobe  (o_strobe),
        .o_result  (o_result),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_job        pending_jobs[$];
    t_qte_euler  expected_angles[$];
    logic [15:0] model_margin = 16'd27;
    int          fail_count = 0;
    int          result_count = 0;
    int          pole_count = 0;
    int          margin_writes = 0;
    int          cycle_count = 0;

    // Vectoring CORDIC arctangent; the answer is a 32-bit fraction of a turn.
    function automatic logic [31:0] cordic_angle(input longint y_in, input longint x_in);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        x = x_in;
        y = y_in;
        z = '0;
        if (x == 0 && y == 0) return '0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< 32) && (y < 0 ? -y : y) < (64'sd1 <<< 32)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            z = TURN_HALF;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Rounds a turn fraction to the 16-bit binary angle.
    function automatic logic [15:0] turn_to_angle(input logic [31:0] z);
        logic [31:0] zr;
        zr = z + 32'h0000_8000;
        return zr[31:16];
    endfunction

    function automatic t_qte_euler euler_of(input t_qte_quat q, input logic [15:0] margin);
        longint          w;
        longint          x;
        longint          y;
        longint          z;
        longint          norm;
        longint          cross2;
        longint          lim;
        longint unsigned s;
        longint unsigned m;
        logic [31:0]     yaw;
        logic [31:0]     pitch;
        logic [31:0]     roll;
        t_qte_euler      r;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        norm = w*w + x*x + y*y + z*z;
        cross2 = 2 * (w*x + y*z);
        lim = norm - 2 * longint'(margin);
        if (cross2 > lim) begin
            yaw = 32'd2 * cordic_angle(y, w);
            pitch = TURN_QUARTER;
            roll = '0;
            r.pole_status = POLE_NORTH;
        end else if (cross2 < -lim) begin
            yaw = 32'd0 - 32'd2 * cordic_angle(y, w);
            pitch = 32'd0 - TURN_QUARTER;
            roll = '0;
            r.pole_status = POLE_SOUTH;
        end else begin
            yaw = cordic_angle(2 * (w*z - x*y), (64'sd1 <<< 28) - 2 * (z*z + x*x));
            roll = cordic_angle(2 * (w*y - x*z), (64'sd1 <<< 28) - 2 * (y*y + x*x));
            if (norm == 0) begin
                pitch = '0;
            end else begin
                s = longint'(cross2 < 0 ? -cross2 : cross2) >> 2;
                m = longint'(norm) >> 2;
                if (s > m) s = m;
                pitch = cordic_angle(longint'(s), longint'(floor_sqrt(m*m - s*s)));
                if (cross2 < 0) pitch = 32'd0 - pitch;
            end
            r.pole_status = POLE_NONE;
        end
        r.yaw_angle = turn_to_angle(yaw);
        r.pitch_angle = turn_to_angle(pitch);
        r.roll_angle = turn_to_angle(roll);
        return r;
    endfunction

    function automatic t_job quat_job(input int w, input int x, input int y, input int z);
        t_job j;
        j.kind = JOB_QUAT;
        j.quat.quat_w = 16'(w);
        j.quat.quat_x = 16'(x);
        j.quat.quat_y = 16'(y);
        j.quat.quat_z = 16'(z);
        j.margin = '0;
        return j;
    endfunction

    function automatic t_job control_job(input t_job_kind kind, input logic [15:0] margin);
        t_job j;
        j.kind = kind;
        j.quat = '0;
        j.margin = margin;
        return j;
    endfunction

    // Random quaternion; a share sits near the poles where the margin decides the outcome.
    function automatic t_job random_quat_job();
        int a;
        int b;
        int sgn;
        case ($urandom_range(0, 3))
            0, 1: return quat_job($urandom, $urandom, $urandom, $urandom);
            2: begin
                a = $urandom_range(0, 23170);
                b = $urandom_range(0, 23170);
                sgn = $urandom_range(0, 1) ? 1 : -1;
                return quat_job(a + $urandom_range(0, 8) - 4, sgn * a + $urandom_range(0, 8) - 4,
                                b + $urandom_range(0, 8) - 4, sgn * b + $urandom_range(0, 8) - 4);
            end
            default: return quat_job($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                                     $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
        endcase
    endfunction

    // Driver: presents one beat at a time, with a random gap drawn after each accepted beat.
    // Margin writes and drain points wait until no result is outstanding.
    t_qte_quat   held_quat;
    int          gap_left = 0;
    int          quiet_cycles = 0;
    always @(posedge i_clk) begin
        logic next_start;
        logic next_we;
        next_start = start;
        next_we = 1'b0;
        if (i_rst_n) begin
            if (expected_angles.size() == 0 && !start && !i_cfg_we) quiet_cycles <= quiet_cycles + 1;
            else quiet_cycles <= 0;
            if (start && !busy) begin
                expected_angles.push_back(euler_of(held_quat, model_margin));
                next_start = 1'b0;
                // A quarter of the beats get no gap; otherwise the gap is drawn at random.
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end else if (start) begin
                // Beat held until busy drops.
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end
            if (!(start && busy) && !(start && !busy && 0) && pending_jobs.size() > 0 &&
                (start && !busy ? 1 : gap_left == 0)) begin
                case (pending_jobs[0].kind)
                    JOB_QUAT: begin
                        if (!(start && !busy) || $urandom_range(0, 3) == 0) begin
                            i_quat <= pending_jobs[0].quat;
                            held_quat <= pending_jobs[0].quat;
                            next_start = 1'b1;
                            void'(pending_jobs.pop_front());
                        end
                    end
                    JOB_MARGIN: begin
                        if (!start && quiet_cycles >= QUIET_CYCLES) begin
                            next_we = 1'b1;
                            i_cfg_data <= pending_jobs[0].margin;
                            model_margin <= pending_jobs[0].margin;
                            margin_writes <= margin_writes + 1;
                            void'(pending_jobs.pop_front());
                        end
                    end
                    default: begin
                        if (expected_angles.size() == 0 && !start) void'(pending_jobs.pop_front());
                    end
                endcase
            end
        end
        start <= next_start;
        i_cfg_we <= next_we;
    end

    // Monitor: every strobed result beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_qte_euler want;
        if (i_rst_n && o_strobe) begin
            if (expected_angles.size() == 0) begin
                $error("result beat with no prediction waiting");
                fail_count <= fail_count + 1;
            end else begin
                want = expected_angles.pop_front();
                result_count <= result_count + 1;
                if (want.pole_status != POLE_NONE) pole_count <= pole_count + 1;
                if (o_result.yaw_angle !== want.yaw_angle) begin
                    $error("yaw_angle: expected %0d, got %0d", want.yaw_angle, o_result.yaw_angle);
                    fail_count <= fail_count + 1;
                end
                if (o_result.pitch_angle !== want.pitch_angle) begin
                    $error("pitch_angle: expected %0d, got %0d",
                           want.pitch_angle, o_result.pitch_angle);
                    fail_count <= fail_count + 1;
                end
                if (o_result.roll_angle !== want.roll_angle) begin
                    $error("roll_angle: expected %0d, got %0d",
                           want.roll_angle, o_result.roll_angle);
                    fail_count <= fail_count + 1;
                end
                if (o_result.pole_status !== want.pole_status) begin
                    $error("pole_status: expected %0d, got %0d",
                           want.pole_status, o_result.pole_status);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_quaternion_to_euler_angles: FAIL");
            $finish;
        end
    end

    logic [15:0] margin_plan[4];
    initial begin
        // Directed beats: extremes, identity, both poles, a tiny norm and atan2 of zero.
        pending_jobs.push_back(quat_job(0, 0, 0, 0));
        pending_jobs.push_back(quat_job(16384, 0, 0, 0));
        pending_jobs.push_back(quat_job(-16384, 0, 0, 0));
        pending_jobs.push_back(quat_job(32767, 32767, 32767, 32767));
        pending_jobs.push_back(quat_job(-32768, -32768, -32768, -32768));
        pending_jobs.push_back(quat_job(-32768, 32767, -32768, 32767));
        pending_jobs.push_back(quat_job(32767, -32768, 0, 0));
        pending_jobs.push_back(quat_job(11585, 11585, 0, 0));
        pending_jobs.push_back(quat_job(11585, -11585, 0, 0));
        pending_jobs.push_back(quat_job(8192, 8192, 8192, 8192));
        pending_jobs.push_back(quat_job(8192, -8192, 8192, -8192));
        pending_jobs.push_back(quat_job(-8192, 8192, 8192, 8192));
        pending_jobs.push_back(quat_job(11586, 11585, 0, 1));
        pending_jobs.push_back(quat_job(1, 0, 0, 0));
        pending_jobs.push_back(quat_job(0, 0, 1, 0));
        pending_jobs.push_back(quat_job(0, 0, 0, 16384));
        pending_jobs.push_back(quat_job(0, 16384, 0, 0));
        pending_jobs.push_back(quat_job(0, 0, -16384, 0));
        pending_jobs.push_back(quat_job(0, 0, 0, -32768));
        // Random phases under different margins, extremes included, then back to reset value.
        margin_plan[0] = 16'd0;
        margin_plan[1] = 16'hFFFF;
        margin_plan[2] = 16'($urandom);
        margin_plan[3] = 16'd27;
        for (int p = 0; p < 4; p++) begin
            pending_jobs.push_back(control_job(JOB_DRAIN, '0));
            pending_jobs.push_back(control_job(JOB_MARGIN, margin_plan[p]));
            for (int k = 0; k < 400; k++) pending_jobs.push_back(random_quat_job());
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_jobs.size() == 0 && !start);
        wait (expected_angles.size() == 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
        $display("checked %0d result beats (%0d at a pole) across %0d margin settings",
                 result_count, pole_count, margin_writes + 1);
        if (fail_count == 0) begin
            $display("tb_quaternion_to_euler_angles: PASS");
        end else begin
            $display("tb_quaternion_to_euler_angles: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_fifo.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/qte_back.sv
hdl/quaternion_to_euler_angles.sv
test/tb_quaternion_to_euler_angles.sv
